@@ sv/dual_order_service_queue_defines.svh @@
// assertion macros used by the queue's top level
`ifndef DUAL_ORDER_SERVICE_QUEUE_DEFINES_SVH
`define DUAL_ORDER_SERVICE_QUEUE_DEFINES_SVH

// same-cycle implication, held off during reset
`define DOSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dosq: same-cycle check failed");

// next-cycle implication, held off during reset
`define DOSQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dosq: next-cycle check failed");

`endif

@@ sv/dosq_pkg.sv @@
// shared constants, codes and controller/datapath interface types
`default_nettype none
package dosq_pkg;
  localparam int CAPACITY    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int ID_BITS     = 32;
  localparam int AMOUNT_BITS = 32;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ENTRY_BITS  = ID_BITS + VALUE_BITS;

  typedef enum logic [1:0] {
    OP_ARRIVE  = 2'd0,
    OP_OLDEST  = 2'd1,
    OP_HIGHEST = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    arrive;
    logic    scan_init;
    logic    sweep;
    logic    shift_init;
    logic    remove;
    logic    finish;
    status_t res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       sweep_done;
  } stat_t;
endpackage
`default_nettype wire

@@ sv/dosq_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module dosq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ sv/dosq_ctrl.sv @@
// controller state machine: dispatch, value scan, compaction sweep
`default_nettype none
module dosq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire dosq_pkg::stat_t stat,
  output dosq_pkg::cmd_t      cmd,
  output logic                busy
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and command decode
  always_comb begin
    cmd            = '0;
    cmd.res_status = dosq_pkg::ST_EMPTY;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          dosq_pkg::OP_ARRIVE: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.res_status = dosq_pkg::ST_FULL;
            end else begin
              cmd.arrive     = 1'b1;
              cmd.res_status = dosq_pkg::ST_ACCEPTED;
            end
            state_next = S_IDLE;
          end
          dosq_pkg::OP_OLDEST, dosq_pkg::OP_HIGHEST: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.res_status = dosq_pkg::ST_EMPTY;
              state_next     = S_IDLE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
            // unused code behaves as a serve on an empty store
            cmd.finish     = 1'b1;
            cmd.res_status = dosq_pkg::ST_EMPTY;
            state_next     = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          cmd.remove     = 1'b1;
          cmd.finish     = 1'b1;
          cmd.res_status = dosq_pkg::ST_SERVED;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end
endmodule
`default_nettype wire

@@ sv/dosq_datapath.sv @@
// datapath: entry store, occupancy, id counter, scan and shift engine, result
`default_nettype none
module dosq_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [1:0]                          operation,
  input  wire logic [dosq_pkg::AMOUNT_BITS-1:0]    amount,
  input  wire dosq_pkg::cmd_t                      cmd,
  output dosq_pkg::stat_t                          stat,
  output logic                                     done,
  output logic [1:0]                               status,
  output logic [dosq_pkg::ID_BITS-1:0]             request_id
);
  localparam int SB = dosq_pkg::SLOT_BITS;
  localparam int CB = dosq_pkg::COUNT_BITS;
  localparam int VB = dosq_pkg::VALUE_BITS;
  localparam int IB = dosq_pkg::ID_BITS;
  localparam int EB = dosq_pkg::ENTRY_BITS;

  logic [1:0]    op;
  logic [VB-1:0] val;
  logic [CB-1:0] occ;
  logic [IB-1:0] next_id;
  logic [CB-1:0] ptr;
  logic [CB-1:0] sweep_end;
  logic          pend;
  logic [SB-1:0] pend_idx;
  logic          shifting;
  logic [SB-1:0] best_idx;
  logic [VB-1:0] best_val;
  logic [IB-1:0] best_id;

  logic          rd_en;
  logic [SB-1:0] raddr;
  logic [EB-1:0] rdata;
  logic          we;
  logic [SB-1:0] waddr;
  logic [EB-1:0] wdata;
  logic [IB-1:0] rd_id;
  logic [VB-1:0] rd_val;

  // entries held in arrival order, slot 0 oldest, as {id, value}
  dosq_ram #(
    .WIDTH (EB),
    .DEPTH (dosq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read issue, write port steering and status
  always_comb begin
    rd_en  = cmd.sweep && (ptr != sweep_end);
    raddr  = ptr[SB-1:0];
    rd_id  = rdata[EB-1:VB];
    rd_val = rdata[VB-1:0];
    we     = cmd.arrive || (cmd.sweep && pend && shifting);
    waddr  = cmd.arrive ? occ[SB-1:0] : (pend_idx - SB'(1));
    wdata  = cmd.arrive ? {next_id, val} : rdata;
    stat.op         = op;
    stat.full       = (occ == CB'(dosq_pkg::CAPACITY));
    stat.empty      = (occ == '0);
    stat.sweep_done = (ptr == sweep_end) && !pend;
  end

  // control state: occupancy, id counter, read pending flag, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      next_id <= IB'(1);
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.arrive) begin
        occ     <= occ + CB'(1);
        next_id <= (next_id == '1) ? IB'(1) : next_id + IB'(1);
      end else if (cmd.remove) begin
        occ <= occ - CB'(1);
      end
      if (cmd.scan_init || cmd.shift_init) begin
        pend <= 1'b0;
      end else if (cmd.sweep) begin
        pend <= rd_en;
      end
    end
  end

  // payload: latched item, sweep pointers, best entry, result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      val <= VB'(amount);
    end
    // scan covers all entries for highest value, only slot 0 for oldest
    if (cmd.scan_init) begin
      ptr       <= '0;
      sweep_end <= (op == dosq_pkg::OP_HIGHEST) ? occ : CB'(1);
      shifting  <= 1'b0;
    end else if (cmd.shift_init) begin
      // move every entry above the served one down by a slot
      ptr       <= CB'(best_idx) + CB'(1);
      sweep_end <= occ;
      shifting  <= 1'b1;
    end else if (cmd.sweep && rd_en) begin
      ptr      <= ptr + CB'(1);
      pend_idx <= ptr[SB-1:0];
    end
    // strict compare keeps the earliest entry on a tie
    if (cmd.sweep && pend && !shifting) begin
      if ((pend_idx == '0) || (rd_val > best_val)) begin
        best_idx <= pend_idx;
        best_val <= rd_val;
        best_id  <= rd_id;
      end
    end
    if (cmd.finish) begin
      status <= cmd.res_status;
      case (cmd.res_status)
        dosq_pkg::ST_ACCEPTED: request_id <= next_id;
        dosq_pkg::ST_SERVED:   request_id <= best_id;
        default:               request_id <= '0;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/dual_order_service_queue.sv @@
// top level: request queue served by arrival order or by highest value
//
//   beat     signals                              handshake
//   request  operation, amount                    taken when start && !busy
//   result   status, request_id                   one-cycle strobe on done
//
// arrive, full, empty and unused codes finish in the dispatch state; a serve
// scans s entries (1 oldest, occupancy highest) and then moves m = occupancy -
// 1 - served slot entries down, one ram read a cycle.
// busy is high from accept until the strobe cycle, where it falls; rst is
// synchronous: store empty, next id 1, ram not cleared; the receiver has no stall.
`default_nettype none
`include "dual_order_service_queue_defines.svh"
module dual_order_service_queue (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [1:0]                       operation,
  input  wire logic [dosq_pkg::AMOUNT_BITS-1:0] amount,
  output logic                                  busy,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [dosq_pkg::ID_BITS-1:0]          request_id
);
  dosq_pkg::cmd_t  cmd;
  dosq_pkg::stat_t stat;
  logic            err_result;

  // sequencing of each item
  dosq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // store, counters and result registers
  dosq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .amount     (amount),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .request_id (request_id)
  );

  // error class of the result on the ports
  assign err_result = (status == dosq_pkg::ST_EMPTY) || (status == dosq_pkg::ST_FULL);

  // checks
  `DOSQ_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `DOSQ_ASSERT_IMP(a_done_idle, done, !busy)
  `DOSQ_ASSERT_IMP(a_err_zero_id, done && err_result, request_id == '0)
  `DOSQ_ASSERT_IMP(a_ok_nonzero_id, done && !err_result, request_id != '0)
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the dual order service queue: directed table, then random phases
module tb_top;
  import dosq_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int         QUIET_TAIL   = 60;

  // phase kinds of the random part
  typedef enum int {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN
  } phase_t;

  typedef struct {
    status_t            status;
    logic [ID_BITS-1:0] id;
  } reply_t;

  typedef struct {
    logic [1:0]             op;
    logic [AMOUNT_BITS-1:0] amt;
    bit                     typed;
    reply_t                 reply;
  } row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic [1:0]             operation = 2'd0;
  logic [AMOUNT_BITS-1:0] amount    = '0;
  logic                   busy;
  logic                   done;
  logic [1:0]             status;
  logic [ID_BITS-1:0]     request_id;

  // mirror of the store, kept in arrival order
  logic [ID_BITS-1:0]    held_ids[$];
  logic [VALUE_BITS-1:0] held_vals[$];
  logic [ID_BITS-1:0]    id_counter;

  reply_t due_replies[$];

  int fail_count     = 0;
  int replies_seen   = 0;
  int requests_sent  = 0;
  int full_rejects   = 0;
  int empty_serves   = 0;
  int peak_depth     = 0;
  int cycle_count    = 0;

  dual_order_service_queue u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .amount     (amount),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .request_id (request_id)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("cycle limit reached with %0d results still due", due_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  // predicted outcome of one request, updating the mirrored store
  function automatic reply_t serve_step(logic [1:0] op, logic [AMOUNT_BITS-1:0] amt);
    reply_t r;
    int     best;
    r.status = ST_EMPTY;
    r.id     = '0;
    case (op)
      OP_ARRIVE: begin
        if (held_ids.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_ACCEPTED;
          r.id     = id_counter;
          held_ids.insert(held_ids.size(), id_counter);
          held_vals.insert(held_vals.size(), amt[VALUE_BITS-1:0]);
          id_counter = (id_counter == '1) ? 1 : id_counter + 1;
        end
      end
      OP_OLDEST, OP_HIGHEST: begin
        if (held_ids.size() != 0) begin
          best = 0;
          // strict compare keeps the earliest arrival on a tie
          if (op == OP_HIGHEST) begin
            for (int k = 1; k < held_vals.size(); k++) begin
              if (held_vals[k] > held_vals[best]) best = k;
            end
          end
          r.status = ST_SERVED;
          r.id     = held_ids[best];
          held_ids.delete(best);
          held_vals.delete(best);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t mk_row(logic [1:0] op, logic [AMOUNT_BITS-1:0] amt, bit typed,
                                  status_t st, logic [ID_BITS-1:0] id);
    row_t row;
    row.op           = op;
    row.amt          = amt;
    row.typed        = typed;
    row.reply.status = st;
    row.reply.id     = id;
    return row;
  endfunction

  // hold one request beat until the block takes it, then record what is due
  task automatic issue_request(logic [1:0] op, logic [AMOUNT_BITS-1:0] amt, bit typed,
                               reply_t typed_reply);
    reply_t r;
    start     <= 1'b1;
    operation <= op;
    amount    <= amt;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    r = serve_step(op, amt);
    if (typed) due_replies.insert(due_replies.size(), typed_reply);
    else due_replies.insert(due_replies.size(), r);
    requests_sent++;
    if (r.status == ST_FULL) full_rejects++;
    if (r.status == ST_EMPTY) empty_serves++;
    if (held_ids.size() > peak_depth) peak_depth = held_ids.size();
  endtask

  // random idle burst, sometimes placed right after the block frees up
  task automatic idle_burst(bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [AMOUNT_BITS-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 7);  // dense values force ties
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_op(phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_UNUSED;
    case (ph)
      PH_FILL:  return (roll < 85) ? OP_ARRIVE : ((roll < 92) ? OP_OLDEST : OP_HIGHEST);
      PH_DRAIN: return (roll < 18) ? OP_ARRIVE : ((roll < 59) ? OP_OLDEST : OP_HIGHEST);
      default:  return (roll < 50) ? OP_ARRIVE : ((roll < 75) ? OP_OLDEST : OP_HIGHEST);
    endcase
  endfunction

  // result checking against the oldest due reply
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && done === 1'b1) begin
      if (due_replies.size() == 0) begin
        $error("unexpected result: status %0d request_id %0d", status, request_id);
        fail_count++;
      end else begin
        want = due_replies.pop_front();
        replies_seen++;
        if (status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, status);
          fail_count++;
        end
        if (request_id !== want.id) begin
          $error("request_id mismatch: expected %0d actual %0d", want.id, request_id);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    row_t   rows[$];
    phase_t plan[$];
    int     lengths[$];
    int     left;
    bit     quiet;
    reply_t none;

    none.status = ST_EMPTY;
    none.id     = '0;
    id_counter  = 1;

    // directed table: empty serves, unused code, extremes, ties on the top value
    rows.insert(rows.size(), mk_row(OP_OLDEST,  32'h0000_0000, 1, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'hFFFF_FFFF, 1, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_UNUSED,  32'h0000_0000, 1, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'h0000_0000, 1, ST_ACCEPTED, 1));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'hFFFF_FFFF, 1, ST_ACCEPTED, 2));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'h8000_0000, 1, ST_ACCEPTED, 3));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'hFFFF_FFFF, 1, ST_ACCEPTED, 4));
    rows.insert(rows.size(), mk_row(OP_UNUSED,  32'hFFFF_FFFF, 1, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'h0000_0000, 1, ST_SERVED,   2));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'hFFFF_FFFF, 1, ST_SERVED,   4));
    rows.insert(rows.size(), mk_row(OP_OLDEST,  32'hFFFF_FFFF, 1, ST_SERVED,   1));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'h7FFF_FFFF, 1, ST_ACCEPTED, 5));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'h0000_0001, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_ARRIVE,  32'h0000_0000, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'h5555_5555, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'hAAAA_AAAA, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_OLDEST,  32'h0000_0000, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'h0000_0000, 0, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_HIGHEST, 32'h0000_0000, 1, ST_EMPTY,    0));
    rows.insert(rows.size(), mk_row(OP_OLDEST,  32'hFFFF_FFFF, 1, ST_EMPTY,    0));

    // random plan: fill past capacity, churn, drain past empty, repeat
    plan    = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_FILL, PH_DRAIN};
    lengths = '{120, 80, 120, 120, 60};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      issue_request(rows[i].op, rows[i].amt, rows[i].typed, rows[i].reply);
      idle_burst(1'b0);
    end

    left = 0;
    foreach (lengths[p]) left += lengths[p];
    foreach (plan[p]) begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat (lengths[p]) begin
        issue_request(pick_op(plan[p]), pick_amount(), 1'b0, none);
        left--;
        idle_burst(quiet || left < QUIET_TAIL);
      end
    end

    // let the last results come back, then watch for strays
    start <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d checked results, store depth up to %0d of %0d",
             requests_sent, replies_seen, peak_depth, CAPACITY);
    $display("full rejections %0d, serves and unused codes on empty %0d",
             full_rejects, empty_serves);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
